/* sv/sia_pkg.sv */
package sia_pkg;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_QUERY  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_IGNORED = 2'd1,
        STS_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_GET
    } state_t;

endpackage

/* sv/sia_ram.sv */
module sia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/sia_step.sv */
// Address step for the tail move: next source entry, its destination, last flag.
module sia_step #(
    parameter int AW = 10,
    parameter int FW = 11
) (
    input  logic [AW-1:0] cursor,
    input  logic [AW-1:0] limit,
    input  logic [FW-1:0] span,
    input  logic          ascend,
    output logic [AW-1:0] next_cursor,
    output logic [AW-1:0] dst_addr,
    output logic          last
);

    localparam int SW = FW + 1;

    logic [SW-1:0] cur_x;
    logic [SW-1:0] span_x;

    assign cur_x  = SW'(cursor);
    assign span_x = SW'(span);

    // erase walks upwards and writes below; insert walks downwards and writes above
    assign dst_addr    = ascend ? AW'(cur_x - span_x) : AW'(cur_x + span_x);
    assign next_cursor = ascend ? cursor + AW'(1) : cursor - AW'(1);
    assign last        = (cursor == limit);

endmodule

/* sv/shift_insert_erase_array_top.sv */
// Channel   Signals                              Handshake
// -------   ----------------------------------   ---------------------------
// command   opcode, position, count, value       start high and busy low
// result    read_value, fill_size, capacity_now, done high for one cycle
//           status
//
// Query, set, continued insert, rejected items and insert or erase with no tail
// to move: result in the cycle after start.
// Get: passes through S_GET (registered RAM read).
// Tail-moving insert: S_SHIFT, S_DRAIN, S_PLACE; erase: S_SHIFT then S_DRAIN.
// The single RAM write port moves one entry per cycle.
// Reset clears fill and run state, capacity is 1; contents are undefined until written.
// Results cannot be stalled; a new item may start in the cycle that done is high.
module shift_insert_erase_array_top #(
    parameter int DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [10:0]        position,
    input  logic [10:0]        count,
    input  logic signed [31:0] value,
    output logic               done,
    output logic signed [31:0] read_value,
    output logic [10:0]        fill_size,
    output logic [11:0]        capacity_now,
    output logic [1:0]         status
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int KW = $clog2(2 * DEPTH + 1);
    localparam int XW = ((FW > 11) ? FW : 11) + 1;

    sia_pkg::state_t  state_reg, state_next;
    sia_pkg::status_t status_reg, status_next;

    logic [FW-1:0] fill_reg, fill_next;
    logic [KW-1:0] cap_reg, cap_next;
    logic          run_active_reg, run_active_next;
    logic [FW-1:0] run_start_reg, run_start_next;
    logic [FW-1:0] run_offset_reg, run_offset_next;
    logic [FW-1:0] run_length_reg, run_length_next;
    logic          done_reg, done_next;
    logic          pend_reg, pend_next;

    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] lim_reg, lim_next;
    logic [FW-1:0] span_reg, span_next;
    logic          asc_reg, asc_next;
    logic          ins_reg, ins_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [31:0]   val_reg, val_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic [31:0]   rdv_reg, rdv_next;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [31:0]   ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [31:0]   ram_rd_data;

    logic [AW-1:0] step_next;
    logic [AW-1:0] step_dst;
    logic          step_last;

    logic [XW-1:0] pos_x, cnt_x, fill_x, need_x, idx_x, tail_x, n_x, end_x;
    logic [KW:0]   cap2_k, need_k;

    sia_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    sia_step #(
        .AW (AW),
        .FW (FW)
    ) u_step (
        .cursor      (cur_reg),
        .limit       (lim_reg),
        .span        (span_reg),
        .ascend      (asc_reg),
        .next_cursor (step_next),
        .dst_addr    (step_dst),
        .last        (step_last)
    );

    assign pos_x  = XW'(position);
    assign cnt_x  = XW'(count);
    assign fill_x = XW'(fill_reg);
    assign need_x = fill_x + cnt_x;
    assign idx_x  = XW'(run_start_reg) + XW'(run_offset_reg);
    assign tail_x = fill_x - pos_x;
    assign n_x    = (cnt_x < tail_x) ? cnt_x : tail_x;
    assign end_x  = pos_x + n_x;
    assign cap2_k = (KW + 1)'(cap_reg) << 1;
    assign need_k = (KW + 1)'(need_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sia_pkg::S_IDLE;
            fill_reg       <= '0;
            cap_reg        <= KW'(1);
            run_active_reg <= 1'b0;
            run_start_reg  <= '0;
            run_offset_reg <= '0;
            run_length_reg <= '0;
            done_reg       <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            cap_reg        <= cap_next;
            run_active_reg <= run_active_next;
            run_start_reg  <= run_start_next;
            run_offset_reg <= run_offset_next;
            run_length_reg <= run_length_next;
            done_reg       <= done_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        lim_reg       <= lim_next;
        span_reg      <= span_next;
        asc_reg       <= asc_next;
        ins_reg       <= ins_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        rdv_reg       <= rdv_next;
        status_reg    <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        cap_next        = cap_reg;
        run_active_next = run_active_reg;
        run_start_next  = run_start_reg;
        run_offset_next = run_offset_reg;
        run_length_next = run_length_reg;
        done_next       = 1'b0;
        pend_next       = 1'b0;
        cur_next        = cur_reg;
        lim_next        = lim_reg;
        span_next       = span_reg;
        asc_next        = asc_reg;
        ins_next        = ins_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        pend_addr_next  = pend_addr_reg;
        rdv_next        = rdv_reg;
        status_next     = status_reg;

        // a moved entry lands in the cycle after its read
        ram_wr_en   = pend_reg;
        ram_wr_addr = pend_addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = cur_reg;

        unique case (state_reg)
            sia_pkg::S_IDLE:
            begin
                if (start)
                begin
                    done_next   = 1'b1;
                    status_next = sia_pkg::STS_DONE;
                    rdv_next    = '0;
                    if (opcode == sia_pkg::OP_INSERT && run_active_reg)
                    begin
                        if (idx_x < fill_x)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = AW'(idx_x);
                            ram_wr_data = value;
                        end
                        run_offset_next = run_offset_reg + FW'(1);
                        if ((run_offset_reg + FW'(1)) >= run_length_reg)
                        begin
                            run_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        run_active_next = 1'b0;
                        unique case (opcode)
                            sia_pkg::OP_INSERT:
                            begin
                                if (pos_x > fill_x)
                                begin
                                    status_next = sia_pkg::STS_IGNORED;
                                end
                                else if (count == '0)
                                begin
                                    status_next = sia_pkg::STS_DONE;
                                end
                                else if (need_x > XW'(DEPTH))
                                begin
                                    status_next = sia_pkg::STS_FULL;
                                end
                                else
                                begin
                                    if (need_k > (KW + 1)'(cap_reg))
                                    begin
                                        cap_next = KW'((cap2_k > need_k) ? cap2_k : need_k);
                                    end
                                    fill_next       = FW'(need_x);
                                    run_start_next  = FW'(position);
                                    run_offset_next = FW'(1);
                                    run_length_next = FW'(count);
                                    run_active_next = (count > 11'd1);
                                    pos_next        = AW'(position);
                                    val_next        = value;
                                    if (fill_x > pos_x)
                                    begin
                                        done_next  = 1'b0;
                                        cur_next   = AW'(fill_x - XW'(1));
                                        lim_next   = AW'(position);
                                        span_next  = FW'(count);
                                        asc_next   = 1'b0;
                                        ins_next   = 1'b1;
                                        state_next = sia_pkg::S_SHIFT;
                                    end
                                    else
                                    begin
                                        ram_wr_en   = 1'b1;
                                        ram_wr_addr = AW'(position);
                                        ram_wr_data = value;
                                    end
                                end
                            end
                            sia_pkg::OP_ERASE:
                            begin
                                if (pos_x >= fill_x || count == '0)
                                begin
                                    status_next = sia_pkg::STS_IGNORED;
                                end
                                else
                                begin
                                    fill_next = FW'(fill_x - n_x);
                                    if (fill_x > end_x)
                                    begin
                                        done_next  = 1'b0;
                                        cur_next   = AW'(end_x);
                                        lim_next   = AW'(fill_x - XW'(1));
                                        span_next  = FW'(n_x);
                                        asc_next   = 1'b1;
                                        ins_next   = 1'b0;
                                        state_next = sia_pkg::S_SHIFT;
                                    end
                                end
                            end
                            sia_pkg::OP_GET:
                            begin
                                if (pos_x < fill_x)
                                begin
                                    done_next   = 1'b0;
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = AW'(position);
                                    state_next  = sia_pkg::S_GET;
                                end
                                else
                                begin
                                    status_next = sia_pkg::STS_IGNORED;
                                end
                            end
                            sia_pkg::OP_SET:
                            begin
                                if (pos_x < fill_x)
                                begin
                                    ram_wr_en   = 1'b1;
                                    ram_wr_addr = AW'(position);
                                    ram_wr_data = value;
                                end
                                else
                                begin
                                    status_next = sia_pkg::STS_IGNORED;
                                end
                            end
                            sia_pkg::OP_QUERY:
                            begin
                                status_next = sia_pkg::STS_DONE;
                            end
                            default:
                            begin
                                status_next = sia_pkg::STS_IGNORED;
                            end
                        endcase
                    end
                end
            end
            sia_pkg::S_SHIFT:
            begin
                ram_rd_en      = 1'b1;
                ram_rd_addr    = cur_reg;
                pend_next      = 1'b1;
                pend_addr_next = step_dst;
                cur_next       = step_next;
                if (step_last)
                begin
                    state_next = sia_pkg::S_DRAIN;
                end
            end
            sia_pkg::S_DRAIN:
            begin
                if (ins_reg)
                begin
                    state_next = sia_pkg::S_PLACE;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = sia_pkg::STS_DONE;
                    rdv_next    = '0;
                    state_next  = sia_pkg::S_IDLE;
                end
            end
            sia_pkg::S_PLACE:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = val_reg;
                done_next   = 1'b1;
                status_next = sia_pkg::STS_DONE;
                rdv_next    = '0;
                state_next  = sia_pkg::S_IDLE;
            end
            sia_pkg::S_GET:
            begin
                done_next   = 1'b1;
                status_next = sia_pkg::STS_DONE;
                rdv_next    = ram_rd_data;
                state_next  = sia_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sia_pkg::S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != sia_pkg::S_IDLE);
    assign done         = done_reg;
    assign read_value   = rdv_reg;
    assign fill_size    = 11'(fill_reg);
    assign capacity_now = 12'(cap_reg);
    assign status       = status_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(DEPTH))
        else $error("fill count beyond depth");

    a_cap_covers_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg >= KW'(fill_reg))
        else $error("capacity below fill count");

    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither running nor finished");

    a_run_offset: assert property (@(posedge clk) disable iff (!rst_n)
        run_active_reg |-> (run_offset_reg < run_length_reg))
        else $error("open insert run past its length");
`endif

endmodule

/* dv/shift_insert_erase_array_top_test.sv */
module shift_insert_erase_array_top_test;

    localparam int ARRAY_DEPTH = 1024;
    localparam logic [2:0] OP_SPARE5 = 3'd5;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    class array_scoreboard;
        typedef struct {
            logic [31:0]      rd;
            logic [10:0]      fill;
            logic [11:0]      cap;
            sia_pkg::status_t st;
        } outcome_t;

        logic [31:0] mem [ARRAY_DEPTH];
        bit          wr  [ARRAY_DEPTH];
        int          fill;
        int          cap;
        bit          run_on;
        int          run_base;
        int          run_off;
        int          run_len;
        outcome_t    pending [$];
        int          errors;
        int          checked;
        int          effective;
        int          peak_fill;

        function new();
            fill = 0;
            cap = 1;
            run_on = 0;
            run_base = 0;
            run_off = 0;
            run_len = 0;
            errors = 0;
            checked = 0;
            effective = 0;
            peak_fill = 0;
            foreach (wr[i])
                wr[i] = 0;
        endfunction

        // a get of a never-written entry must not be issued
        function bit readable(int pos);
            return (pos >= fill) || wr[pos];
        endfunction

        function void note_item(logic [2:0] op, logic [10:0] pos, logic [10:0] cnt,
                                logic [31:0] val);
            outcome_t r;
            int p;
            int c;
            int n;
            int idx;
            p = pos;
            c = cnt;
            r.rd = '0;
            r.st = sia_pkg::STS_DONE;
            if (op == sia_pkg::OP_INSERT && run_on)
            begin
                idx = run_base + run_off;
                if (idx < fill && idx < ARRAY_DEPTH)
                begin
                    mem[idx] = val;
                    wr[idx] = 1;
                end
                run_off++;
                if (run_off >= run_len)
                    run_on = 0;
            end
            else
            begin
                run_on = 0;
                case (op)
                    sia_pkg::OP_INSERT:
                    begin
                        if (p > fill)
                            r.st = sia_pkg::STS_IGNORED;
                        else if (c != 0 && fill + c > ARRAY_DEPTH)
                            r.st = sia_pkg::STS_FULL;
                        else if (c != 0)
                        begin
                            if (fill + c > cap)
                                cap = (2 * cap > fill + c) ? 2 * cap : fill + c;
                            for (int i = fill - 1; i >= p; i--)
                            begin
                                mem[i + c] = mem[i];
                                wr[i + c] = wr[i];
                            end
                            fill = fill + c;
                            mem[p] = val;
                            wr[p] = 1;
                            run_base = p;
                            run_off = 1;
                            run_len = c;
                            run_on = (c > 1);
                        end
                    end
                    sia_pkg::OP_ERASE:
                    begin
                        if (p >= fill || c == 0)
                            r.st = sia_pkg::STS_IGNORED;
                        else
                        begin
                            n = (c < fill - p) ? c : fill - p;
                            for (int i = p; i < fill - n; i++)
                            begin
                                mem[i] = mem[i + n];
                                wr[i] = wr[i + n];
                            end
                            fill = fill - n;
                        end
                    end
                    sia_pkg::OP_GET:
                    begin
                        if (p < fill)
                            r.rd = mem[p];
                        else
                            r.st = sia_pkg::STS_IGNORED;
                    end
                    sia_pkg::OP_SET:
                    begin
                        if (p < fill)
                        begin
                            mem[p] = val;
                            wr[p] = 1;
                        end
                        else
                            r.st = sia_pkg::STS_IGNORED;
                    end
                    sia_pkg::OP_QUERY: ;
                    default: r.st = sia_pkg::STS_IGNORED;
                endcase
            end
            r.fill = fill[10:0];
            r.cap = cap[11:0];
            if (r.st == sia_pkg::STS_DONE)
                effective++;
            if (fill > peak_fill)
                peak_fill = fill;
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] rd, logic [10:0] fs, logic [11:0] cp,
                                   logic [1:0] st);
            outcome_t e;
            if (pending.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (rd !== e.rd)
            begin
                $error("read_value: expected %0d, got %0d", $signed(e.rd), $signed(rd));
                errors++;
            end
            if (fs !== e.fill)
            begin
                $error("fill_size: expected %0d, got %0d", e.fill, fs);
                errors++;
            end
            if (cp !== e.cap)
            begin
                $error("capacity_now: expected %0d, got %0d", e.cap, cp);
                errors++;
            end
            if (st !== e.st)
            begin
                $error("status: expected %0d, got %0d", e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         opcode = '0;
    logic [10:0]        position = '0;
    logic [10:0]        count = '0;
    logic signed [31:0] value = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] read_value;
    logic [10:0]        fill_size;
    logic [11:0]        capacity_now;
    logic [1:0]         status;

    array_scoreboard sb;
    int sent = 0;
    int idle_pct = 0;

    shift_insert_erase_array_top #(
        .DEPTH(ARRAY_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .position(position),
        .count(count),
        .value(value),
        .done(done),
        .read_value(read_value),
        .fill_size(fill_size),
        .capacity_now(capacity_now),
        .status(status)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(read_value, fill_size, capacity_now, status);
    end

    // start stays high into the next item unless an idle gap is drawn
    task automatic send(input logic [2:0] op, input int pos, input int cnt,
                        input logic [31:0] val);
        start <= 1'b1;
        opcode <= op;
        position <= pos[10:0];
        count <= cnt[10:0];
        value <= val;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(op, pos[10:0], cnt[10:0], val);
        sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic other_item(input logic [2:0] op);
        int pos;
        int cnt;
        int f;
        f = sb.fill;
        pos = $urandom_range(0, 2047);
        cnt = $urandom_range(0, 2047);
        if (op == sia_pkg::OP_ERASE)
        begin
            if (f > 0 && $urandom_range(99) < 85)
            begin
                pos = $urandom_range(0, f - 1);
                cnt = ($urandom_range(99) < 8) ? $urandom_range(f - pos, 2047)
                                               : $urandom_range(1, 8);
            end
            else if (f > 0 && $urandom_range(1))
            begin
                pos = $urandom_range(0, f - 1);
                cnt = 0;
            end
            else
                pos = $urandom_range(f, 2047);
        end
        else if (op == sia_pkg::OP_GET || op == sia_pkg::OP_SET)
        begin
            if (f > 0 && $urandom_range(99) < 85)
                pos = $urandom_range(0, f - 1);
            else
                pos = $urandom_range(f, 2047);
        end
        if (op == sia_pkg::OP_GET && !sb.readable(pos))
            op = sia_pkg::OP_SET;
        send(op, pos, cnt, $urandom);
    endtask

    task automatic insert_run(input int pos, input int cnt, input bit cut);
        int stop_at;
        int k;
        stop_at = (cut && cnt > 2) ? $urandom_range(1, cnt - 2) : cnt;
        send(sia_pkg::OP_INSERT, pos, cnt, $urandom);
        k = 1;
        // position and count are don't-care on continuation items
        while (sb.run_on && k < stop_at)
        begin
            send(sia_pkg::OP_INSERT, $urandom_range(0, 2047), $urandom_range(0, 2047),
                 $urandom);
            k++;
        end
        if (sb.run_on)
            other_item($urandom_range(sia_pkg::OP_ERASE, sia_pkg::OP_QUERY));
    endtask

    task automatic random_item();
        int roll;
        int pos;
        int cnt;
        int f;
        roll = $urandom_range(99);
        f = sb.fill;
        if (f > 200 && $urandom_range(1))
            other_item(sia_pkg::OP_ERASE);
        else if (roll < 38)
        begin
            pos = ($urandom_range(99) < 90) ? $urandom_range(0, f) : $urandom_range(f + 1, 2047);
            roll = $urandom_range(99);
            if (roll < 70)
                cnt = $urandom_range(1, 4);
            else if (roll < 88)
                cnt = $urandom_range(5, 16);
            else if (roll < 93)
                cnt = 0;
            else if (roll < 97)
                cnt = $urandom_range(17, 64);
            else
                cnt = $urandom_range(ARRAY_DEPTH + 1 - f, 2047);
            insert_run(pos, cnt, $urandom_range(99) < 12);
        end
        else if (roll < 52)
            other_item(sia_pkg::OP_ERASE);
        else if (roll < 68)
            other_item(sia_pkg::OP_GET);
        else if (roll < 82)
            other_item(sia_pkg::OP_SET);
        else if (roll < 92)
            other_item(sia_pkg::OP_QUERY);
        else
            other_item($urandom_range(OP_SPARE5, OP_SPARE7));
    endtask

    initial
    begin
        int goal;
        int old_fill;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(sia_pkg::OP_QUERY, 0, 0, 0);
        send(sia_pkg::OP_GET, 0, 0, 0);
        send(sia_pkg::OP_ERASE, 0, 1, 0);
        send(sia_pkg::OP_INSERT, 1, 1, 5);
        send(sia_pkg::OP_INSERT, 0, 0, 5);
        send(sia_pkg::OP_INSERT, 0, 1, 32'h7fff_ffff);
        send(sia_pkg::OP_INSERT, 0, 3, 32'h8000_0000);
        send(sia_pkg::OP_INSERT, 11'h7ff, 11'h7ff, 32'hffff_ffff);
        send(sia_pkg::OP_INSERT, 0, 0, 0);
        send(sia_pkg::OP_INSERT, 4, 1, 32'h1234_5678);
        // run of three cut after its first element; the gap keeps stale data
        send(sia_pkg::OP_INSERT, 2, 3, 32'h0bad_cafe);
        send(sia_pkg::OP_GET, 0, 0, 0);
        send(sia_pkg::OP_GET, 4, 0, 0);
        send(sia_pkg::OP_SET, 6, 0, 32'hdead_beef);
        send(sia_pkg::OP_GET, 6, 0, 0);
        send(OP_SPARE5, 0, 0, 0);
        send(OP_SPARE5 + 3'd1, 0, 0, 0);
        send(OP_SPARE7, 11'h7ff, 11'h7ff, 32'hffff_ffff);
        send(sia_pkg::OP_ERASE, 1, 2, 0);
        send(sia_pkg::OP_ERASE, 3, 11'h7ff, 0);
        send(sia_pkg::OP_ERASE, 0, 0, 0);
        send(sia_pkg::OP_INSERT, 0, ARRAY_DEPTH, 0);
        send(sia_pkg::OP_GET, 11'h7ff, 0, 0);
        send(sia_pkg::OP_SET, ARRAY_DEPTH, 0, 32'h5555_aaaa);
        send(sia_pkg::OP_QUERY, 11'h7ff, 11'h7ff, 32'hffff_ffff);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = (ph == 0) ? 12 : (ph == 1) ? 60 : 0;
            goal = sb.effective + 150;
            while (sb.effective < goal)
                random_item();
            drain();
        end

        // fill to the brim with an append run, then back off
        old_fill = sb.fill;
        send(sia_pkg::OP_INSERT, old_fill, ARRAY_DEPTH - old_fill, $urandom);
        send(sia_pkg::OP_QUERY, 0, 0, 0);
        send(sia_pkg::OP_INSERT, 0, 1, $urandom);
        send(sia_pkg::OP_SET, ARRAY_DEPTH - 1, 0, 32'h8000_0001);
        send(sia_pkg::OP_GET, ARRAY_DEPTH - 1, 0, 0);
        send(sia_pkg::OP_ERASE, old_fill, 11'h7ff, 0);
        send(sia_pkg::OP_QUERY, 0, 0, 0);
        drain();
        repeat (1100) @(posedge clk);

        $display("Sent %0d items: insert runs (whole, cut short, full), erase, get, set,",
                 sent);
        $display("query and spare opcodes; %0d results checked, peak fill %0d, capacity %0d",
                 sb.checked, sb.peak_fill, sb.cap);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/sia_pkg.sv
sv/sia_ram.sv
sv/sia_step.sv
sv/shift_insert_erase_array_top.sv
dv/shift_insert_erase_array_top_test.sv
